// ===== design/hrct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrct_pkg: shared types and constants for the hashed radiance cache table
// Item structs, codes and the key hash mixing functions.
// ----------------------------------------------------------------------------
package hrct_pkg;

   localparam int SLOTS     = 1024;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int ENTRY_W   = 32 * 3 + 7 + 48 + 8 + 32;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_QUERY  = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_NEW     = 3'd0,
      ST_UPDATED = 3'd1,
      ST_EVICTED = 3'd2,
      ST_DROPPED = 3'd3,
      ST_HIT     = 3'd4,
      ST_MISS    = 3'd5,
      ST_CLEARED = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      CSR_CAPACITY = 2'd0,
      CSR_PROBE    = 2'd1,
      CSR_ACCUM    = 2'd2,
      CSR_STALE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic signed [31:0] cell_x;
      logic signed [31:0] cell_y;
      logic signed [31:0] cell_z;
      logic [2:0]  face;
      logic [3:0]  level;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [31:0] frame;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_red;
      logic [15:0] out_green;
      logic [15:0] out_blue;
      logic [31:0] dropped_count;
      logic [31:0] evicted_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] cell_x;
      logic [31:0] cell_y;
      logic [31:0] cell_z;
      logic [6:0]  face_level;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [7:0]  samples;
      logic [31:0] last_frame;
   } entry_type;

   // Queue entry from front to back: request plus its home slot.
   typedef struct packed {
      req_type            req;
      logic [SLOT_W-1:0]  home;
   } job_type;

   typedef struct packed {
      logic [10:0] probes;
      logic [7:0]  accum;
      logic [31:0] stale;
      logic [SLOT_W-1:0] mask;
   } cfg_type;

   // 32-bit mixing step without the multiplies (those go through registers).
   function automatic logic [31:0] xs16(input logic [31:0] v);
      return v ^ (v >> 16);
   endfunction

   function automatic logic [31:0] xs13(input logic [31:0] v);
      return v ^ (v >> 13);
   endfunction

endpackage
`default_nettype wire

// ===== design/hrct_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrct_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module hrct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== design/hrct_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrct_front: request intake and key hash
// Runs the murmur-style mix one step per cycle and emits a job with its home slot.
// ----------------------------------------------------------------------------
module hrct_front
   import hrct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic [SLOT_W-1:0] mask,
   output logic         job_valid,
   input  wire logic    job_stall,
   output job_type      job_data
);
   typedef enum logic [1:0] {F_IDLE, F_MIX, F_OUT} fstate_type;

   fstate_type  state_ff;
   req_type     req_ff;
   logic [4:0]  step_ff;
   logic [2:0]  word_ff;
   logic [31:0] v_ff, v_in;
   logic [31:0] h_ff;
   logic [SLOT_W-1:0] home_ff;

   // Word sequence: x*C0, y*C1, z*C2, fl, then final mix of h.
   // Steps per word: 0 premul, 1 xs16, 2 mul, 3 xs13, 4 mul, 5 xs16.
   logic [31:0] word_src;
   logic [31:0] word_mul;

   always_comb begin
      case (word_ff)
         3'd0:    begin word_src = req_ff.cell_x; word_mul = 32'h9E3779B9; end
         3'd1:    begin word_src = req_ff.cell_y; word_mul = 32'h85EBCA6B; end
         3'd2:    begin word_src = req_ff.cell_z; word_mul = 32'hC2B2AE35; end
         3'd3:    begin
            word_src = {21'd0, req_ff.face, 4'd0, req_ff.level};
            word_mul = 32'd1;
         end
         default: begin word_src = h_ff; word_mul = 32'd1; end
      endcase
      case (step_ff)
         5'd0:    v_in = word_src * word_mul;
         5'd1:    v_in = xs16(v_ff);
         5'd2:    v_in = v_ff * 32'h85EBCA6B;
         5'd3:    v_in = xs13(v_ff);
         5'd4:    v_in = v_ff * 32'hC2B2AE35;
         default: v_in = xs16(v_ff);
      endcase
   end

   assign req_stall = (state_ff != F_IDLE);
   assign job_valid = (state_ff == F_OUT);
   assign job_data  = '{req: req_ff, home: home_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
         word_ff  <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  h_ff     <= '0;
                  step_ff  <= '0;
                  word_ff  <= '0;
                  state_ff <= F_MIX;
               end
            end
            F_MIX: begin
               v_ff <= v_in;
               if (step_ff == 5'd5) begin
                  step_ff <= '0;
                  if (word_ff == 3'd4) begin
                     home_ff  <= v_in[SLOT_W-1:0] & mask;
                     state_ff <= F_OUT;
                  end else begin
                     h_ff    <= h_ff ^ v_in;
                     word_ff <= word_ff + 3'd1;
                  end
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            F_OUT: begin
               if (!job_stall) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 5'd5) else $error("hash step out of range");
   a_word_range: assert property (@(posedge clock) disable iff (reset)
      word_ff <= 3'd4) else $error("hash word out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      job_valid && job_stall |=> job_valid && $stable(job_data))
      else $error("job changed while stalled");
endmodule
`default_nettype wire

// ===== design/hrct_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrct_queue: two-entry job queue between front and back
// Decouples hashing from probing so each side stalls on its own.
// ----------------------------------------------------------------------------
module hrct_queue
   import hrct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire job_type in_data,
   output logic         out_valid,
   input  wire logic    out_stall,
   output job_type      out_data
);
   job_type   slot_ff [2];
   logic      rd_ff, wr_ff;
   logic [1:0] cnt_ff;
   logic      push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> rd_ff == wr_ff)
      else $error("queue pointers inconsistent");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 2'd1) else $error("pop count");
endmodule
`default_nettype wire

// ===== design/hrct_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrct_back: probe engine
// Walks the table over one or two passes, updates entries, keeps the totals.
// ----------------------------------------------------------------------------
module hrct_back
   import hrct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   output logic         job_stall,
   input  wire job_type job_data,
   input  wire cfg_type cfg,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   typedef enum logic [3:0] {
      B_INIT, B_IDLE, B_ADDR, B_WAIT, B_CHECK, B_DIV, B_WRITE, B_RESP, B_CLEAR
   } bstate_type;

   bstate_type state_ff;
   job_type    job_ff;
   logic [SLOT_W-1:0] slot_ff, addr;
   logic [10:0] count_ff;
   logic        pass2_ff;
   logic [31:0] dropped_ff, evicted_ff;
   rsp_type     rsp_ff;
   rsp_type     work_ff;
   logic        rsp_valid_ff;
   entry_type   ent_ff, rd_entry, wr_entry;
   logic        wr_en;
   logic [SLOT_W-1:0] init_ff;
   logic        clearing;
   logic        used_wr;
   logic        used_rd;
   logic        used_ent_ff;

   // Divider state: three channels, restoring, 16-bit magnitude by 8-bit w.
   logic [1:0]  ch_ff;
   logic [4:0]  bit_ff;
   logic [15:0] quo_ff;
   logic [8:0]  rem_ff;
   logic [15:0] mag_ff;
   logic        neg_ff;
   logic [7:0]  w_ff;
   logic [15:0] newc_ff [3];

   logic [7:0] acc1;
   logic [31:0] stale1;
   logic [10:0] probes1;
   assign acc1    = (cfg.accum == 8'd0) ? 8'd1 : cfg.accum;
   assign stale1  = (cfg.stale == 32'd0) ? 32'd1 : cfg.stale;
   assign probes1 = (cfg.probes == 11'd0) ? 11'd1 : cfg.probes;

   logic key_eq;
   assign key_eq = ent_ff.cell_x == job_ff.req.cell_x
                && ent_ff.cell_y == job_ff.req.cell_y
                && ent_ff.cell_z == job_ff.req.cell_z
                && ent_ff.face_level == {job_ff.req.face, job_ff.req.level};

   logic [15:0] oldc, newin;
   always_comb begin
      case (ch_ff)
         2'd0:    begin oldc = ent_ff.red;   newin = job_ff.req.red;   end
         2'd1:    begin oldc = ent_ff.green; newin = job_ff.req.green; end
         default: begin oldc = ent_ff.blue;  newin = job_ff.req.blue;  end
      endcase
   end

   logic [8:0] rem_sh;
   assign rem_sh = {rem_ff[7:0], mag_ff[15]};

   // Entry written on new or eviction.
   entry_type fresh;
   assign fresh = '{cell_x: job_ff.req.cell_x, cell_y: job_ff.req.cell_y,
                    cell_z: job_ff.req.cell_z,
                    face_level: {job_ff.req.face, job_ff.req.level},
                    red: job_ff.req.red, green: job_ff.req.green,
                    blue: job_ff.req.blue, samples: 8'd1,
                    last_frame: job_ff.req.frame};

   logic write_fresh;
   always_comb begin
      wr_en    = (state_ff == B_WRITE);
      clearing = (state_ff == B_INIT) || (state_ff == B_CLEAR);
      // Clearing walks the used marks one slot a cycle.
      addr     = clearing ? init_ff : slot_ff;
      used_wr  = wr_en || clearing;
      wr_entry = fresh;
      if (!write_fresh) begin
         wr_entry = '{cell_x: ent_ff.cell_x, cell_y: ent_ff.cell_y,
                      cell_z: ent_ff.cell_z, face_level: ent_ff.face_level,
                      red: newc_ff[0], green: newc_ff[1], blue: newc_ff[2],
                      samples: w_ff, last_frame: job_ff.req.frame};
      end
   end
   assign write_fresh = (work_ff.status != ST_UPDATED);

   hrct_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr),
      .wr_data (wr_entry),
      .rd_data (rd_entry)
   );

   hrct_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used (
      .clock   (clock),
      .wr_en   (used_wr),
      .addr    (addr),
      .wr_data (wr_en),
      .rd_data (used_rd)
   );

   assign job_stall = (state_ff != B_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         init_ff      <= '0;
         dropped_ff   <= '0;
         evicted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         pass2_ff     <= 1'b0;
         ch_ff        <= '0;
         bit_ff       <= '0;
      end else begin
         case (state_ff)
            B_INIT: begin
               init_ff <= init_ff + 1'b1;
               if (init_ff == SLOT_W'(SLOTS - 1)) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job_data;
                  slot_ff  <= job_data.home;
                  count_ff <= '0;
                  pass2_ff <= 1'b0;
                  work_ff  <= '0;
                  case (job_data.req.kind)
                     KIND_INSERT, KIND_QUERY: state_ff <= B_ADDR;
                     KIND_CLEAR: begin
                        dropped_ff <= '0;
                        evicted_ff <= '0;
                        state_ff   <= B_CLEAR;
                     end
                     default: begin
                        work_ff.status <= ST_MISS;
                        state_ff       <= B_RESP;
                     end
                  endcase
               end
            end
            B_CLEAR: begin
               init_ff <= init_ff + 1'b1;
               if (init_ff == SLOT_W'(SLOTS - 1)) begin
                  work_ff.status <= ST_CLEARED;
                  state_ff       <= B_RESP;
               end
            end
            B_ADDR: state_ff <= B_WAIT;
            B_WAIT: begin
               ent_ff      <= rd_entry;
               used_ent_ff <= used_rd;
               state_ff    <= B_CHECK;
            end
            B_CHECK: begin
               if (!pass2_ff) begin
                  if (!used_ent_ff) begin
                     if (job_ff.req.kind == KIND_INSERT) begin
                        work_ff.status <= ST_NEW;
                        state_ff       <= B_WRITE;
                     end else begin
                        work_ff.status <= ST_MISS;
                        state_ff       <= B_RESP;
                     end
                  end else if (key_eq) begin
                     if (job_ff.req.kind == KIND_INSERT) begin
                        work_ff.status <= ST_UPDATED;
                        w_ff   <= ({1'b0, ent_ff.samples} + 9'd1 < {1'b0, acc1})
                                  ? ent_ff.samples + 8'd1 : acc1;
                        ch_ff  <= '0;
                        bit_ff <= '0;
                        state_ff <= B_DIV;
                     end else begin
                        work_ff.status    <= ST_HIT;
                        work_ff.out_red   <= ent_ff.red;
                        work_ff.out_green <= ent_ff.green;
                        work_ff.out_blue  <= ent_ff.blue;
                        state_ff          <= B_RESP;
                     end
                  end else if (count_ff + 11'd1 >= probes1) begin
                     if (job_ff.req.kind == KIND_INSERT) begin
                        pass2_ff <= 1'b1;
                        count_ff <= '0;
                        slot_ff  <= job_ff.home;
                        state_ff <= B_ADDR;
                     end else begin
                        work_ff.status <= ST_MISS;
                        state_ff       <= B_RESP;
                     end
                  end else begin
                     count_ff <= count_ff + 11'd1;
                     slot_ff  <= (slot_ff + 1'b1) & cfg.mask;
                     state_ff <= B_ADDR;
                  end
               end else begin
                  if (job_ff.req.frame - ent_ff.last_frame >= stale1) begin
                     work_ff.status <= ST_EVICTED;
                     evicted_ff     <= evicted_ff + 32'd1;
                     state_ff       <= B_WRITE;
                  end else if (count_ff + 11'd1 >= probes1) begin
                     work_ff.status <= ST_DROPPED;
                     dropped_ff     <= dropped_ff + 32'd1;
                     state_ff       <= B_RESP;
                  end else begin
                     count_ff <= count_ff + 11'd1;
                     slot_ff  <= (slot_ff + 1'b1) & cfg.mask;
                     state_ff <= B_ADDR;
                  end
               end
            end
            B_DIV: begin
               // One quotient bit a cycle over |new - old| / w.
               if (bit_ff == 5'd0) begin
                  neg_ff <= newin < oldc;
                  mag_ff <= (newin < oldc) ? oldc - newin : newin - oldc;
                  rem_ff <= '0;
                  quo_ff <= '0;
                  bit_ff <= 5'd1;
               end else if (bit_ff <= 5'd16) begin
                  if (rem_sh >= {1'b0, w_ff}) begin
                     rem_ff <= rem_sh - {1'b0, w_ff};
                     quo_ff <= {quo_ff[14:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[14:0], 1'b0};
                  end
                  mag_ff <= {mag_ff[14:0], 1'b0};
                  bit_ff <= bit_ff + 5'd1;
               end else begin
                  newc_ff[ch_ff] <= neg_ff ? oldc - quo_ff : oldc + quo_ff;
                  bit_ff <= '0;
                  if (ch_ff == 2'd2) begin
                     state_ff <= B_WRITE;
                  end else begin
                     ch_ff <= ch_ff + 2'd1;
                  end
               end
            end
            B_WRITE: state_ff <= B_RESP;
            B_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff <= '{status: work_ff.status, out_red: work_ff.out_red,
                              out_green: work_ff.out_green,
                              out_blue: work_ff.out_blue,
                              dropped_count: dropped_ff,
                              evicted_count: evicted_ff};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
         if (rsp_valid_ff && !rsp_stall && state_ff != B_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (work_ff.status == ST_NEW || work_ff.status == ST_UPDATED
                 || work_ff.status == ST_EVICTED)) else $error("stray write");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff < probes1 || state_ff == B_IDLE) else $error("probe overrun");
endmodule
`default_nettype wire

// ===== design/hashed_radiance_cache_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_radiance_cache_table: hashed radiance cache with linear probing
// Top level: configuration registers, hash front, job queue, probe back.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_stall/req_data; each produces exactly one
// response on rsp_valid/rsp_stall/rsp_data. Registers are written on the
// csr_ port (index 0 capacity_log2, 1 max_probe, 2 accumulation_frames,
// 3 stale_frames); ready is always high.
// The front runs the key mix one multiply or shift-xor step per cycle, six
// steps over five words, and takes a new item only once its job has left;
// a two-entry queue lets the next key hash while the back probes.
// The back picks up a job in B_IDLE, reads each probed slot on the single
// RAM port through B_ADDR, B_WAIT and B_CHECK, runs the three-channel
// running-average divide in B_DIV on an update, and writes and responds
// through B_WRITE and B_RESP. Throughput is set by the slower of the front
// and the probe walk. A clear item walks all 1024 used marks, one per cycle,
// before it responds. Reset sets the totals and registers to their defaults
// and runs the same walk before the back takes its first job. A stalled
// response holds its register; the back waits there.
// ----------------------------------------------------------------------------
module hashed_radiance_cache_table
   import hrct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   logic [3:0]  cap_ff;
   logic [10:0] probe_ff;
   logic [7:0]  accum_ff;
   logic [31:0] stale_ff;
   cfg_type     cfg;
   logic [3:0]  lg;
   logic [SLOT_W-1:0] mask;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= 4'd10;
         probe_ff <= 11'd8;
         accum_ff <= 8'd32;
         stale_ff <= 32'd60;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CAPACITY: cap_ff   <= csr_data[3:0];
            CSR_PROBE:    probe_ff <= csr_data[10:0];
            CSR_ACCUM:    accum_ff <= csr_data[7:0];
            CSR_STALE:    stale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      lg = (cap_ff == 4'd0) ? 4'd1 : cap_ff;
      if ({28'd0, lg} > SLOT_W) begin
         lg = 4'(SLOT_W);
      end
      mask = SLOT_W'((32'd1 << lg) - 32'd1);
   end

   assign cfg = '{probes: probe_ff, accum: accum_ff, stale: stale_ff, mask: mask};

   logic    f_valid, f_stall, b_valid, b_stall;
   job_type f_data, b_data;

   hrct_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .mask(mask),
      .job_valid(f_valid), .job_stall(f_stall), .job_data(f_data)
   );

   hrct_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
   );

   hrct_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(b_valid), .job_stall(b_stall), .job_data(b_data),
      .cfg(cfg),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   a_cap: assert property (@(posedge clock) disable iff (reset)
      mask[0] == 1'b1) else $error("capacity mask below two slots");
   a_req_ok: assert property (@(posedge clock) disable iff (reset)
      $past(csr_valid && csr_index == CSR_ACCUM) |-> accum_ff == $past(csr_data[7:0]))
      else $error("accum register write lost");
   a_probe_ok: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == CSR_PROBE |=> probe_ff == $past(csr_data[10:0]))
      else $error("probe register write lost");
endmodule
`default_nettype wire

// ===== dv/hashed_radiance_cache_table_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_radiance_cache_table_test: regression bench for the radiance cache
// Drives insert, query, clear and no-op items through several register settings,
// predicts every response with a local copy of the table and compares them.
// ----------------------------------------------------------------------------
module hashed_radiance_cache_table_test;
   import hrct_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   hashed_radiance_cache_table uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // Local copy of the table and its registers.
   logic [3:0]  cap_lg = 4'd10;
   logic [10:0] probe_cfg = 11'd8;
   logic [7:0]  accum_cfg = 8'd32;
   logic [31:0] stale_cfg = 32'd60;
   bit          tused [SLOTS];
   logic [31:0] tx [SLOTS], ty [SLOTS], tz [SLOTS], tlast [SLOTS];
   logic [6:0]  tfl [SLOTS];
   logic [15:0] trad [SLOTS][3];
   logic [7:0]  tsamp [SLOTS];
   logic [31:0] dropped_tot = '0, evicted_tot = '0;

   req_type pending [$];
   rsp_type expected_rsp [$];
   int      errors = 0;
   int      send_idle_pct = 0, recv_stall_pct = 0;
   logic    req_taken = 1'b0;

   // Random stimulus state
   req_type key_pool [POOL];
   logic [31:0] cur_frame = '0;

   function automatic logic [31:0] mix32(input logic [31:0] v);
      v = v ^ (v >> 16);
      v = v * 32'h85EBCA6B;
      v = v ^ (v >> 13);
      v = v * 32'hC2B2AE35;
      v = v ^ (v >> 16);
      return v;
   endfunction

   function automatic rsp_type predict_lookup(input req_type q);
      rsp_type r;
      int unsigned lg, cap, probes, acc, stale, w;
      logic [31:0] home, s;
      logic [6:0] fl;
      logic [15:0] nv [3];
      int oldv, d;
      bit done;
      r = '0;
      r.status = ST_MISS;
      done = 0;
      lg = (cap_lg < 1) ? 1 : cap_lg;
      cap = 1 << lg;
      while (cap > SLOTS) cap = cap >> 1;
      probes = (probe_cfg < 1) ? 1 : probe_cfg;
      acc = (accum_cfg < 1) ? 1 : accum_cfg;
      stale = (stale_cfg < 1) ? 1 : stale_cfg;
      fl = {q.face, q.level};
      nv[0] = q.red; nv[1] = q.green; nv[2] = q.blue;
      home = mix32(q.cell_x * 32'h9E3779B9) ^ mix32(q.cell_y * 32'h85EBCA6B)
           ^ mix32(q.cell_z * 32'hC2B2AE35) ^ mix32({21'd0, q.face, 4'd0, q.level});
      home = mix32(home);
      if (q.kind == KIND_CLEAR) begin
         foreach (tused[k]) tused[k] = 0;
         dropped_tot = '0;
         evicted_tot = '0;
         r.status = ST_CLEARED;
      end else if (q.kind == KIND_INSERT) begin
         for (int i = 0; i < probes && !done; i++) begin
            s = (home + i) & (cap - 1);
            if (!tused[s]) begin
               tused[s] = 1;
               tx[s] = q.cell_x; ty[s] = q.cell_y; tz[s] = q.cell_z; tfl[s] = fl;
               for (int c = 0; c < 3; c++) trad[s][c] = nv[c];
               tsamp[s] = 8'd1; tlast[s] = q.frame;
               r.status = ST_NEW;
               done = 1;
            end else if (tx[s] == q.cell_x && ty[s] == q.cell_y && tz[s] == q.cell_z
                         && tfl[s] == fl) begin
               w = tsamp[s] + 1;
               if (w > acc) w = acc;
               for (int c = 0; c < 3; c++) begin
                  oldv = int'(trad[s][c]);
                  d = int'(nv[c]) - oldv;
                  trad[s][c] = 16'(oldv + d / int'(w));
               end
               tsamp[s] = 8'(w); tlast[s] = q.frame;
               r.status = ST_UPDATED;
               done = 1;
            end
         end
         for (int i = 0; i < probes && !done; i++) begin
            s = (home + i) & (cap - 1);
            if (32'(q.frame - tlast[s]) >= stale) begin
               tx[s] = q.cell_x; ty[s] = q.cell_y; tz[s] = q.cell_z; tfl[s] = fl;
               for (int c = 0; c < 3; c++) trad[s][c] = nv[c];
               tsamp[s] = 8'd1; tlast[s] = q.frame;
               evicted_tot = evicted_tot + 1;
               r.status = ST_EVICTED;
               done = 1;
            end
         end
         if (!done) begin
            dropped_tot = dropped_tot + 1;
            r.status = ST_DROPPED;
         end
      end else if (q.kind == KIND_QUERY) begin
         for (int i = 0; i < probes && !done; i++) begin
            s = (home + i) & (cap - 1);
            if (!tused[s]) begin
               done = 1;
            end else if (tx[s] == q.cell_x && ty[s] == q.cell_y && tz[s] == q.cell_z
                         && tfl[s] == fl) begin
               r.out_red = trad[s][0]; r.out_green = trad[s][1]; r.out_blue = trad[s][2];
               r.status = ST_HIT;
               done = 1;
            end
         end
      end
      r.dropped_count = dropped_tot;
      r.evicted_count = evicted_tot;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (got !== want) begin
         errors++;
         $display("%0t mismatch %s: got %h expected %h", $realtime, field, got, want);
      end
   endtask

   // Driver: present items and response stalls at the falling edge.
   always @(posedge clock) req_taken <= req_valid && !req_stall;

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Predict on each accepted item.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) expected_rsp.push_back(predict_lookup(req_data));
   end

   // Monitor: compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t response with no item outstanding", $realtime);
         end else begin
            want = expected_rsp.pop_front();
            report_mismatch("status", rsp_data.status, want.status);
            report_mismatch("out_red", rsp_data.out_red, want.out_red);
            report_mismatch("out_green", rsp_data.out_green, want.out_green);
            report_mismatch("out_blue", rsp_data.out_blue, want.out_blue);
            report_mismatch("dropped_count", rsp_data.dropped_count, want.dropped_count);
            report_mismatch("evicted_count", rsp_data.evicted_count, want.evicted_count);
         end
      end
   end

   task automatic push_item(input kind_type k, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [2:0] f, input logic [3:0] lv,
                            input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                            input logic [31:0] fr);
      req_type q;
      q.kind = k; q.cell_x = x; q.cell_y = y; q.cell_z = z; q.face = f; q.level = lv;
      q.red = r; q.green = g; q.blue = b; q.frame = fr;
      pending.push_back(q);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CAPACITY: cap_lg = val[3:0];
         CSR_PROBE:    probe_cfg = val[10:0];
         CSR_ACCUM:    accum_cfg = val[7:0];
         default:      stale_cfg = val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending.size() != 0 || req_valid || expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic req_type fresh_key();
      req_type q;
      q = '0;
      q.cell_x = $urandom; q.cell_y = $urandom; q.cell_z = $urandom;
      if ($urandom_range(1)) begin
         q.cell_x = $signed(32'($urandom_range(7))) - 4;
         q.cell_y = $signed(32'($urandom_range(7))) - 4;
      end
      q.face = $urandom_range(7);
      q.level = $urandom_range(15);
      return q;
   endfunction

   task automatic add_random(input int n);
      req_type q;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if ($urandom_range(9) < 7) q = key_pool[$urandom_range(POOL - 1)];
         else q = fresh_key();
         if ($urandom_range(9) == 0) key_pool[$urandom_range(POOL - 1)] = fresh_key();
         if (pick < 55) q.kind = KIND_INSERT;
         else if (pick < 93) q.kind = KIND_QUERY;
         else if (pick < 97) q.kind = KIND_CLEAR;
         else q.kind = KIND_NONE;
         q.red = $urandom_range(65535);
         q.green = $urandom_range(65535);
         q.blue = $urandom_range(65535);
         // Advance time slowly, with an occasional jump anywhere.
         if ($urandom_range(19) == 0) cur_frame = $urandom;
         else cur_frame = cur_frame + $urandom_range(4);
         q.frame = cur_frame;
         pending.push_back(q);
      end
   endtask

   task automatic run_phase(input int mode, input logic [31:0] lg, input logic [31:0] pr,
                            input logic [31:0] ac, input logic [31:0] st, input int n);
      wait_drained();
      write_csr(CSR_CAPACITY, lg);
      write_csr(CSR_PROBE, pr);
      write_csr(CSR_ACCUM, ac);
      write_csr(CSR_STALE, st);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
         default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      push_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, cur_frame);
      add_random(n);
   endtask

   initial begin
      foreach (key_pool[k]) key_pool[k] = fresh_key();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: four slots, four probes, so the table fills quickly.
      write_csr(CSR_CAPACITY, 2);
      write_csr(CSR_PROBE, 4);
      write_csr(CSR_ACCUM, 3);
      write_csr(CSR_STALE, 10);
      push_item(KIND_QUERY, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0);
      push_item(KIND_INSERT, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0);
      push_item(KIND_INSERT, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
      push_item(KIND_INSERT, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 16'h1234, 16'hFFFF, 2);
      push_item(KIND_QUERY, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 2);
      push_item(KIND_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7, 4'd15,
                16'hFFFF, 0, 16'h8000, 3);
      push_item(KIND_INSERT, 1, 2, 3, 3'd6, 4'd1, 16'h0100, 16'h0200, 16'h0300, 3);
      push_item(KIND_INSERT, 5, 6, 7, 3'd2, 4'd9, 16'h00FF, 16'hFF00, 16'h0F0F, 4);
      push_item(KIND_INSERT, 8, 9, 10, 3'd5, 4'd3, 1, 2, 3, 4);
      push_item(KIND_INSERT, 11, 12, 13, 3'd1, 4'd4, 7, 8, 9, 5);
      push_item(KIND_QUERY, 99, 98, 97, 3'd0, 4'd2, 0, 0, 0, 5);
      push_item(KIND_INSERT, 20, 21, 22, 3'd4, 4'd7, 16'hAAAA, 16'h5555, 16'hFFFF, 40);
      push_item(KIND_QUERY, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7, 4'd15, 0, 0, 0, 40);
      push_item(KIND_NONE, 1, 2, 3, 3'd6, 4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 41);
      push_item(KIND_INSERT, 30, 31, 32, 3'd3, 4'd0, 4, 5, 6, 32'hFFFFFFFF);
      push_item(KIND_INSERT, 40, 41, 42, 3'd3, 4'd8, 4, 5, 6, 32'h00000005);
      push_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 6);
      push_item(KIND_QUERY, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 6);
      push_item(KIND_INSERT, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7);

      run_phase(0, 1, 1, 1, 1, 40);
      run_phase(1, 3, 4, 255, 32'hFFFFFFFF, 70);
      run_phase(2, 0, 0, 0, 0, 40);
      run_phase(3, 4, 8, 8, 20, 90);
      run_phase(0, 10, 1024, 32, 60, 15);
      run_phase(1, 15, 2047, 5, 3, 15);
      run_phase(2, 2, 6, 2, 4, 90);
      run_phase(3, 3, 3, 4, 6, 40);
      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("hashed_radiance_cache_table regression: pass");
      end else begin
         $display("hashed_radiance_cache_table regression: fail");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("hashed_radiance_cache_table regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
